// ----- hdl/kct_pkg.sv -----
`timescale 1ns / 1ps

package kct_pkg;

    localparam int CAPACITY = 16;
    // Count holds 0..CAPACITY; index addresses 0..CAPACITY-1.
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam int KEY_W   = 16;
    localparam int VALUE_W = 32;
    localparam int ECNT_W  = 5;

    // Operation codes
    localparam logic [1:0] OP_SET = 2'd0;
    localparam logic [1:0] OP_GET = 2'd1;
    localparam logic [1:0] OP_DEL = 2'd2;
    localparam logic [1:0] OP_CLR = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]                 mode;
        logic signed [KEY_W-1:0]    key;
        logic signed [VALUE_W-1:0]  cat_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]                 status;
        logic signed [VALUE_W-1:0]  value_out;
        logic [ECNT_W-1:0]          entry_count;
    } out_item_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } entry_t;

endpackage

// ----- hdl/keyed_category_table_unit.sv -----
`timescale 1ns / 1ps

// Keyed category table: ordered table of up to CAPACITY (key, value) pairs.
// Input channel (s_valid/s_ready/s_data) carries one operation per
// transaction: set, get, delete or clear. Result channel
// (m_valid/m_ready/m_data) returns exactly one transaction per operation:
// status, value read (get hit only, else zero) and entry count afterwards.
// A sequencer walks the table one entry per cycle through a single key
// comparator. A search stops at the matching entry, a miss at the entry
// count; delete then moves every later entry down one place, one entry
// per cycle. The result then goes to the output register. The slowest
// operation is a miss on a full table; clear skips the walk.
// s_ready is high only while the sequencer is idle: one operation at a time,
// the next one accepted in the same cycle that the previous result appears.
// The output register holds a finished result while m_ready is low; the
// sequencer waits in its final state until the register is free, so a
// stalled receiver never loses a result.
// Reset (aresetn low, synchronous) empties the table and drops any pending
// result. Stored entries are not cleared; only entries below the count are
// ever read.
module keyed_category_table_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  kct_pkg::in_item_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output kct_pkg::out_item_t m_data
);
    import kct_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    in_item_t         op_reg, op_next;
    out_item_t        res_reg, res_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_data_reg, m_data_next;

    // Table storage: flops, one read address per cycle
    entry_t           entry_reg [CAPACITY];
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    entry_t           wr_entry;
    logic [IDX_W-1:0] rd_idx;
    entry_t           rd_entry;
    logic             key_hit;
    logic             at_end;

    // SHIFT reads the next entry up; SCAN reads the current one.
    assign rd_idx   = (state_reg == S_SHIFT) ? IDX_W'(idx_reg + 1'b1) : idx_reg[IDX_W-1:0];
    assign rd_entry = entry_reg[rd_idx];
    assign key_hit  = (rd_entry.key == op_reg.key);
    assign at_end   = (idx_reg == count_reg);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        op_next      = op_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        wr_en        = 1'b0;
        wr_idx       = idx_reg[IDX_W-1:0];
        wr_entry     = '{key: op_reg.key, value: op_reg.cat_value};

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_data;
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                res_next.value_out = '0;
                res_next.status    = ST_OK;
                if (op_reg.mode == OP_CLR) begin
                    count_next = '0;
                    state_next = S_DONE;
                end else if (at_end) begin
                    // Key absent
                    state_next = S_DONE;
                    if (op_reg.mode == OP_SET) begin
                        if (count_reg == CNT_W'(CAPACITY)) begin
                            res_next.status = ST_FULL;
                        end else begin
                            wr_en      = 1'b1;
                            wr_idx     = count_reg[IDX_W-1:0];
                            count_next = count_reg + 1'b1;
                        end
                    end else begin
                        res_next.status = ST_MISSING;
                    end
                end else if (key_hit) begin
                    case (op_reg.mode)
                        OP_SET: begin
                            wr_en          = 1'b1;
                            wr_entry.key   = rd_entry.key;
                            state_next     = S_DONE;
                        end
                        OP_GET: begin
                            res_next.value_out = rd_entry.value;
                            state_next         = S_DONE;
                        end
                        default: begin
                            // Delete: close the gap unless it is the last entry
                            if (CNT_W'(idx_reg + 1'b1) == count_reg) begin
                                count_next = count_reg - 1'b1;
                                state_next = S_DONE;
                            end else begin
                                state_next = S_SHIFT;
                            end
                        end
                    endcase
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_SHIFT: begin
                wr_en    = 1'b1;
                wr_entry = rd_entry;
                idx_next = idx_reg + 1'b1;
                if (CNT_W'(idx_reg + 2'd2) == count_reg) begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next             = res_reg;
                    m_data_next.entry_count = ECNT_W'(count_reg);
                    state_next              = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
        if (wr_en) begin
            entry_reg[wr_idx] <= wr_entry;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (idx_reg <= count_reg))
        else $error("scan index past entry count");

    a_shift_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT) |-> (CNT_W'(idx_reg + 2'd2) <= count_reg))
        else $error("shift reads past last entry");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_FULL) |-> (m_data.entry_count == ECNT_W'(CAPACITY)))
        else $error("full status with table not full");

    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != ST_OK) |-> (m_data.value_out == '0))
        else $error("nonzero value on failed operation");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

// Keyed category table testbench.
// Directed rows first, then random phases of set/get/delete/clear traffic
// drawn from a small key pool per phase so lookups hit, the table fills up
// and deletes shift live entries. Every accepted transaction is run through
// a local copy of the table; its expected result is queued and compared field by
// field against the result channel.
module tb_top;
    import kct_pkg::*;

    localparam int N_DIR       = 24;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_LEN   = 128;
    localparam int LONG_HOLD   = 300;          // receiver freeze, cycles
    localparam int DRAIN_WAIT  = 2 * CAPACITY + 8;
    // Budget: ~1060 transactions, each at the worst block time plus a sender
    // and a receiver gap, plus one long hold; taken several times over.
    localparam int CYCLE_LIMIT = 400000;

    logic       aclk;
    logic       aresetn  = 1'b0;
    logic       s_valid  = 1'b0;
    logic       s_ready;
    in_item_t   s_data   = '0;
    logic       m_valid;
    logic       m_ready  = 1'b0;
    out_item_t  m_data;

    keyed_category_table_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Local copy of the table, updated once per accepted transaction.
    // ------------------------------------------------------------------
    logic [KEY_W-1:0]   tbl_key [CAPACITY];
    logic [VALUE_W-1:0] tbl_val [CAPACITY];
    int                 tbl_cnt = 0;

    out_item_t          pending_results [$];   // oldest result first
    int                 err_cnt   = 0;
    int                 cycle_cnt = 0;

    // Knobs shared between stimulus and receiver.
    int                 tx_idle_pct = 0;
    int                 rx_idle_pct = 0;
    bit                 quiet_tail  = 1'b0;    // no idling at all
    bit                 rx_hold_req = 1'b0;    // ask receiver for a long freeze

    logic [KEY_W-1:0]   key_pool [32];

    // Apply one operation to the local table and return its result.
    // First match wins; a miss leaves pos at the entry count.
    function automatic out_item_t table_apply(input in_item_t op);
        out_item_t r;
        int        pos;
        r.status    = ST_OK;
        r.value_out = '0;
        pos = tbl_cnt;
        // Scan downward so the lowest matching index is what remains.
        for (int i = tbl_cnt - 1; i >= 0; i--) begin
            if (tbl_key[i] == op.key)
                pos = i;
        end
        case (op.mode)
            OP_SET: begin
                if (pos < tbl_cnt) begin
                    tbl_val[pos] = op.cat_value;
                end else if (tbl_cnt >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    tbl_key[tbl_cnt] = op.key;
                    tbl_val[tbl_cnt] = op.cat_value;
                    tbl_cnt++;
                end
            end
            OP_GET: begin
                if (pos < tbl_cnt)
                    r.value_out = tbl_val[pos];
                else
                    r.status = ST_MISSING;
            end
            OP_DEL: begin
                if (pos < tbl_cnt) begin
                    // close the gap, order kept
                    for (int j = pos; j + 1 < tbl_cnt; j++) begin
                        tbl_key[j] = tbl_key[j + 1];
                        tbl_val[j] = tbl_val[j + 1];
                    end
                    tbl_cnt--;
                end else begin
                    r.status = ST_MISSING;
                end
            end
            default: begin
                tbl_cnt = 0;     // clear: stale data stays, but is dead
            end
        endcase
        r.entry_count = ECNT_W'(tbl_cnt);
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        err_cnt++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Input side. Valid goes up with its payload and holds until the
    // transaction is taken; the expectation is queued at that edge.
    // A typed expectation replaces the local one for directed rows.
    // ------------------------------------------------------------------
    task automatic offer(input in_item_t it, input bit use_typed, input out_item_t typed);
        out_item_t got;
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        got = table_apply(it);
        pending_results.push_back(use_typed ? typed : got);
    endtask

    // Random sender gap, only outside the quiet tail.
    task automatic tx_gap();
        int n;
        if (!quiet_tail && $urandom_range(0, 99) < tx_idle_pct) begin
            n = $urandom_range(1, 13);
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // Mostly pool keys so lookups hit and the table fills; a few fully
    // random keys as noise. Clear kept rare so full is reachable.
    function automatic in_item_t pick_op(input int pool_n);
        in_item_t it;
        int       r;
        r            = $urandom_range(0, 99);
        it.cat_value = $urandom;
        it.key       = key_pool[$urandom_range(0, pool_n - 1)];
        if (r < 42)
            it.mode = OP_SET;
        else if (r < 70)
            it.mode = OP_GET;
        else if (r < 99)
            it.mode = OP_DEL;
        else
            it.mode = OP_CLR;
        if ($urandom_range(0, 99) < 8)
            it.key = KEY_W'($urandom_range(0, 16'hFFFF));
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Directed rows. rep > 1 repeats a set with key+i and a random value,
    // checked against the local table; chk rows carry a typed result.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [1:0]          mode;
        logic [KEY_W-1:0]    key;
        logic [VALUE_W-1:0]  val;
        logic [7:0]          rep;
        logic                chk;
        logic [1:0]          st;
        logic [VALUE_W-1:0]  vout;
        logic [ECNT_W-1:0]   cnt;
    } dir_row_t;

    dir_row_t dir_rows [N_DIR] = '{
        // empty table: misses and a clear that does nothing
        '{OP_GET, 16'h0000, 32'hDEADBEEF, 8'd1,  1'b1, ST_MISSING, 32'h0,        5'd0},
        '{OP_DEL, 16'h8000, 32'h00000000, 8'd1,  1'b1, ST_MISSING, 32'h0,        5'd0},
        '{OP_CLR, 16'hFFFF, 32'hFFFFFFFF, 8'd1,  1'b1, ST_OK,      32'h0,        5'd0},
        // extreme keys and values
        '{OP_SET, 16'h8000, 32'h80000000, 8'd1,  1'b1, ST_OK,      32'h0,        5'd1},
        '{OP_SET, 16'h7FFF, 32'h7FFFFFFF, 8'd1,  1'b1, ST_OK,      32'h0,        5'd2},
        '{OP_SET, 16'h0000, 32'h00000000, 8'd1,  1'b1, ST_OK,      32'h0,        5'd3},
        '{OP_SET, 16'hFFFF, 32'hFFFFFFFF, 8'd1,  1'b1, ST_OK,      32'h0,        5'd4},
        '{OP_GET, 16'h8000, 32'h7FFFFFFF, 8'd1,  1'b1, ST_OK,      32'h80000000, 5'd4},
        '{OP_GET, 16'hFFFF, 32'h00000000, 8'd1,  1'b1, ST_OK,      32'hFFFFFFFF, 5'd4},
        // overwrite in place
        '{OP_SET, 16'h7FFF, 32'h5AA5C33C, 8'd1,  1'b1, ST_OK,      32'h0,        5'd4},
        '{OP_GET, 16'h7FFF, 32'h12345678, 8'd1,  1'b1, ST_OK,      32'h5AA5C33C, 5'd4},
        // delete head, everything shifts down
        '{OP_DEL, 16'h8000, 32'hA5A5A5A5, 8'd1,  1'b1, ST_OK,      32'h0,        5'd3},
        '{OP_GET, 16'h8000, 32'h00000000, 8'd1,  1'b1, ST_MISSING, 32'h0,        5'd3},
        '{OP_GET, 16'h0000, 32'hFFFFFFFF, 8'd1,  1'b1, ST_OK,      32'h0,        5'd3},
        // fill to capacity with keys 0x0100..0x010C
        '{OP_SET, 16'h0100, 32'h00000000, 8'd13, 1'b0, ST_OK,      32'h0,        5'd0},
        // full: new key refused, existing key still overwritten
        '{OP_SET, 16'h1234, 32'h00000001, 8'd1,  1'b1, ST_FULL,    32'h0,        5'd16},
        '{OP_SET, 16'h7FFF, 32'h00000001, 8'd1,  1'b1, ST_OK,      32'h0,        5'd16},
        '{OP_GET, 16'h7FFF, 32'h00000000, 8'd1,  1'b1, ST_OK,      32'h00000001, 5'd16},
        '{OP_GET, 16'h1234, 32'h00000000, 8'd1,  1'b1, ST_MISSING, 32'h0,        5'd16},
        // delete from the middle and the tail
        '{OP_DEL, 16'hFFFF, 32'h00000000, 8'd1,  1'b1, ST_OK,      32'h0,        5'd15},
        '{OP_DEL, 16'h010C, 32'h00000000, 8'd1,  1'b1, ST_OK,      32'h0,        5'd14},
        // clear drops everything; old keys must miss afterwards
        '{OP_CLR, 16'h1234, 32'h5555AAAA, 8'd1,  1'b1, ST_OK,      32'h0,        5'd0},
        '{OP_GET, 16'h7FFF, 32'h00000000, 8'd1,  1'b1, ST_MISSING, 32'h0,        5'd0},
        '{OP_SET, 16'h7FFF, 32'h00000002, 8'd1,  1'b1, ST_OK,      32'h0,        5'd1}
    };

    // ------------------------------------------------------------------
    // Stimulus: reset, directed rows, random phases, drain, verdict.
    // ------------------------------------------------------------------
    initial begin : stimulus
        in_item_t  it;
        out_item_t want;
        dir_row_t  row;
        int        pool_n;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 20;
        rx_idle_pct = 20;
        for (int d = 0; d < N_DIR; d++) begin
            row = dir_rows[d];
            for (int i = 0; i < row.rep; i++) begin
                it.mode      = row.mode;
                it.key       = row.key + KEY_W'(i);
                it.cat_value = (row.rep > 1) ? VALUE_W'($urandom) : row.val;
                want.status      = row.st;
                want.value_out   = row.vout;
                want.entry_count = row.cnt;
                tx_gap();
                offer(it, row.chk, want);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // pool size drawn per phase, below or above capacity
            pool_n = $urandom_range(6, 28);
            for (int k = 0; k < 32; k++)
                key_pool[k] = KEY_W'($urandom);

            if (ph == 0) begin
                tx_idle_pct = 0;             // back-to-back stretch
                rx_idle_pct = 0;
            end else begin
                tx_idle_pct = $urandom_range(0, 40);
                rx_idle_pct = $urandom_range(0, 40);
            end

            if (ph == 2) begin
                // Receiver freezes while the sender keeps pushing, so the
                // output register fills and s_ready drops.
                tx_idle_pct = 0;
                rx_hold_req = 1'b1;
            end

            if (ph == 5) begin
                // Sender goes quiet until every outstanding result is back.
                s_valid <= 1'b0;
                do
                    @(posedge aclk);
                while (pending_results.size() != 0);
            end

            if (ph == NUM_PHASES - 1)
                quiet_tail = 1'b1;

            for (int n = 0; n < PHASE_LEN; n++) begin
                tx_gap();
                offer(pick_op(pool_n), 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (err_cnt == 0)
            $display("keyed_category_table_unit test passed");
        else
            $display("keyed_category_table_unit test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, one long freeze on request,
    // and none at all in the quiet tail.
    // ------------------------------------------------------------------
    initial begin : receiver
        int n;
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (!quiet_tail && $urandom_range(0, 99) < rx_idle_pct) begin
                n = $urandom_range(1, 13);
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result check: each accepted transaction against the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("result with nothing pending: st=%0d val=%h cnt=%0d",
                                        m_data.status, m_data.value_out, m_data.entry_count));
            end else begin
                want = pending_results.pop_front();
                if (m_data.status !== want.status)
                    flag_mismatch($sformatf("status %0d, want %0d",
                                            m_data.status, want.status));
                if (m_data.value_out !== want.value_out)
                    flag_mismatch($sformatf("value_out %h, want %h",
                                            m_data.value_out, want.value_out));
                if (m_data.entry_count !== want.entry_count)
                    flag_mismatch($sformatf("entry_count %0d, want %0d",
                                            m_data.entry_count, want.entry_count));
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("keyed_category_table_unit test failed");
            $finish;
        end
    end

endmodule

// ----- files.f -----
hdl/kct_pkg.sv
hdl/keyed_category_table_unit.sv
sim/tb_top.sv
